// File: hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_seq, the top level and the testbench.
`default_nettype none
package spq_pkg;

  // Default queue depth (number of entries).
  localparam int SPQ_DEPTH_DEF = 16;

  // Fixed field widths of the channel words.
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;
  localparam int ENTRY_W = 2 * DATA_W;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Input word
  typedef struct packed {
    cmd_t                     command;
    logic signed [DATA_W-1:0] item_data;
    logic signed [DATA_W-1:0] item_priority;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [DATA_W-1:0] head_data;
    logic signed [DATA_W-1:0] head_priority;
    logic                     is_empty;
    logic                     is_full;
    logic [COUNT_W-1:0]       entry_count;
    status_t                  status;
  } out_word_t;

  // One stored entry, as held in the slot RAM
  typedef struct packed {
    logic signed [DATA_W-1:0] prio;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  // Signed ordering of priorities: a served before b
  function automatic logic prio_less(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
    return a < b;
  endfunction

endpackage : spq_pkg
`default_nettype wire

// File: hdl/spq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module spq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output      logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : spq_ram
`default_nettype wire

// File: hdl/spq_seq.sv
// Sequencer and datapath of the sorted priority queue: insertion walk,
// head pointer, fill count and result assembly. Uses spq_pkg; drives spq_ram.
`default_nettype none
module spq_seq import spq_pkg::*; #(
  parameter int DEPTH = SPQ_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input word
  input  wire logic                                  in_valid,
  output      logic                                  in_ready,
  input  wire in_word_t                              in_word,
  // result towards the output register
  output      logic                                  res_valid,
  input  wire logic                                  res_ready,
  output      out_word_t                             res_word,
  // slot RAM
  output      logic                                  ram_wr_en,
  output      logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_wr_addr,
  output      logic [ENTRY_W-1:0]                    ram_wr_data,
  output      logic                                  ram_rd_en,
  output      logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_rd_addr,
  input  wire logic [ENTRY_W-1:0]                    ram_rd_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_INS_RD  = 5'b00010,
    S_INS_CMP = 5'b00100,
    S_HEAD_RD = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     head_r,  head_nxt;
  logic [CNT_W-1:0]     occ_r,   occ_nxt;
  logic [IDX_W-1:0]     pos_r,   pos_nxt;
  status_t              status_r, status_nxt;
  entry_t               new_r,   new_nxt;

  logic [IDX_W-1:0]     lidx;
  logic [IDX_W:0]       psum;
  logic [IDX_W-1:0]     paddr;
  entry_t               rd_ent;
  logic                 goes_here;
  logic                 is_empty;

  assign rd_ent = ram_rd_data;

  // logical slot -> physical RAM address (circular, head at logical 0)
  // at the head the walk writes logical 0 itself, not the slot above it
  always_comb begin
    if (state_r == S_INS_RD && pos_r != '0) begin
      lidx = pos_r - IDX_W'(1);
    end else if (state_r == S_HEAD_RD) begin
      lidx = '0;
    end else begin
      lidx = pos_r;
    end
    psum = {1'b0, head_r} + {1'b0, lidx};
    if (psum >= (IDX_W + 1)'(DEPTH)) begin
      paddr = IDX_W'(psum - (IDX_W + 1)'(DEPTH));
    end else begin
      paddr = psum[IDX_W-1:0];
    end
  end

  // compare: new entry lands above the slot just read
  assign goes_here = prio_less(rd_ent.prio, new_r.prio);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    occ_nxt     = occ_r;
    pos_nxt     = pos_r;
    status_nxt  = status_r;
    new_nxt     = new_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_data = new_r;
    ram_rd_en   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          new_nxt    = '{prio: in_word.item_priority, data: in_word.item_data};
          status_nxt = ST_OK;
          state_nxt  = S_HEAD_RD;
          if (in_word.command == CMD_INSERT) begin
            if (occ_r == CNT_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              pos_nxt   = occ_r[IDX_W-1:0];
              state_nxt = S_INS_RD;
            end
          end else begin
            if (occ_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              head_nxt = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
              occ_nxt  = occ_r - CNT_W'(1);
            end
          end
        end
      end
      S_INS_RD: begin
        if (pos_r == '0) begin
          // reached the head: new entry becomes the head
          ram_wr_en = 1'b1;
          occ_nxt   = occ_r + CNT_W'(1);
          state_nxt = S_HEAD_RD;
        end else begin
          ram_rd_en = 1'b1;
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ram_wr_en = 1'b1;
        if (goes_here) begin
          occ_nxt   = occ_r + CNT_W'(1);
          state_nxt = S_HEAD_RD;
        end else begin
          // move the read entry one slot towards the tail
          ram_wr_data = rd_ent;
          pos_nxt     = pos_r - IDX_W'(1);
          state_nxt   = S_INS_RD;
        end
      end
      S_HEAD_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ram_wr_addr = paddr;
  assign ram_rd_addr = paddr;

  // result word, head taken from the read just done
  assign is_empty = (occ_r == '0);
  always_comb begin
    res_word.head_data     = is_empty ? '0 : rd_ent.data;
    res_word.head_priority = is_empty ? '0 : rd_ent.prio;
    res_word.is_empty      = is_empty;
    res_word.is_full       = (occ_r == CNT_W'(DEPTH));
    res_word.entry_count   = COUNT_W'(occ_r);
    res_word.status        = status_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    new_r    <= new_nxt;
  end

endmodule : spq_seq
`default_nettype wire

// File: hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: sequencer, slot RAM, output register.
// Depends on spq_pkg, spq_ram and spq_seq.
//
//  channel  signals                          word type   direction
//  in       in_valid / in_ready / in_word     in_word_t   command in
//  out      out_valid / out_ready / out_word  out_word_t  result out
//
// Entries sit in one circular RAM in sorted order; a removal moves the
// head pointer and then reads the head; a dropped insert only reads the
// head. An insert walks from the tail towards the head, reading each entry
// it passes, then comparing and writing, and reads the head once placed.
// in_ready is high only while idle.
// Reset clears count and head pointer at once; no clearing pass is needed.
// A stalled result waits in the output register while the next word is taken.
`default_nettype none
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = SPQ_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_word_t  in_word,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_word_t out_word
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic               res_valid;
  logic               res_ready;
  out_word_t          res_word;
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r;

  spq_seq #(.DEPTH(DEPTH)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_word    (res_word),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  spq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule : sorted_priority_queue
`default_nettype wire

// File: sim/sorted_priority_queue_tb.sv
// Self-checking testbench for sorted_priority_queue: drives insert and remove words,
// predicts every result word with a sorted-array model and compares field by field.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int QDEPTH       = SPQ_DEPTH_DEF;
  localparam int RANDOM_WORDS = 1300;
  localparam int TAIL_WORDS   = 150;      // last stretch with no idling
  localparam int HOLD_AT      = 300;      // words taken before the long receive stall
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 2 * QDEPTH + 12;
  localparam int WATCHDOG_NS  = 10_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  // testbench state
  in_word_t  feed_q[$];
  out_word_t expected_reports[$];
  logic      in_took = 1'b0;
  logic      tail_phase = 1'b0;
  logic      hold_off = 1'b0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        words_taken = 0;
  int        reports_seen = 0;
  int        error_count = 0;
  int        total_words = 0;

  // model of the queue contents, kept sorted, head at index 0
  logic signed [DATA_W-1:0] model_data [QDEPTH];
  logic signed [DATA_W-1:0] model_prio [QDEPTH];
  int                       model_count = 0;

  sorted_priority_queue #(.DEPTH(QDEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    error_count++;
    $display("[%0t] MISMATCH word %0d: %s", $realtime, reports_seen, msg);
  endtask

  // Apply one command to the model and build the result word it should produce
  task automatic advance_queue_model(input in_word_t w, output out_word_t r);
    int pos;
    int i;
    r = '0;
    r.status = ST_OK;
    if (w.command == CMD_INSERT) begin
      if (model_count >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        // new entry goes after strictly smaller priorities, ahead of equal ones
        pos = 0;
        while (pos < model_count && model_prio[pos] < w.item_priority) pos++;
        for (i = model_count; i > pos; i--) begin
          model_data[i] = model_data[i-1];
          model_prio[i] = model_prio[i-1];
        end
        model_data[pos] = w.item_data;
        model_prio[pos] = w.item_priority;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        for (i = 0; i + 1 < model_count; i++) begin
          model_data[i] = model_data[i+1];
          model_prio[i] = model_prio[i+1];
        end
        model_count--;
      end
    end
    if (model_count != 0) begin
      r.head_data     = model_data[0];
      r.head_priority = model_prio[0];
    end
    r.is_empty    = (model_count == 0);
    r.is_full     = (model_count >= QDEPTH);
    r.entry_count = COUNT_W'(model_count);
  endtask

  function automatic in_word_t make_word(input cmd_t c, input logic signed [DATA_W-1:0] d,
                                         input logic signed [DATA_W-1:0] p);
    in_word_t w;
    w.command       = c;
    w.item_data     = d;
    w.item_priority = p;
    return w;
  endfunction

  // Priority picker: narrow band for ties, full range, or an extreme
  function automatic logic signed [DATA_W-1:0] pick_priority();
    logic signed [DATA_W-1:0] p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: p = DATA_W'($urandom_range(0, 8)) - 32'sd4;
      4:          p = 32'sh8000_0000;
      5:          p = 32'sh7fff_ffff;
      default:    p = $urandom;
    endcase
    return p;
  endfunction

  // Driver: present the next word at the falling edge, hold it until taken
  always @(negedge clk) begin
    tail_phase <= (feed_q.size() < TAIL_WORDS);
    if (rst_n && !(in_valid && !in_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (feed_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else begin
        in_word  <= feed_q.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check results, then feed accepted commands to the model
  always @(posedge clk) begin
    out_word_t want;
    out_word_t pred;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          flag_mismatch("result word with nothing pending");
        end else begin
          want = expected_reports.pop_front();
          if (out_word.head_data !== want.head_data)
            flag_mismatch($sformatf("head_data %0d, want %0d",
                                    out_word.head_data, want.head_data));
          if (out_word.head_priority !== want.head_priority)
            flag_mismatch($sformatf("head_priority %0d, want %0d",
                                    out_word.head_priority, want.head_priority));
          if (out_word.is_empty !== want.is_empty)
            flag_mismatch($sformatf("is_empty %b, want %b", out_word.is_empty, want.is_empty));
          if (out_word.is_full !== want.is_full)
            flag_mismatch($sformatf("is_full %b, want %b", out_word.is_full, want.is_full));
          if (out_word.entry_count !== want.entry_count)
            flag_mismatch($sformatf("entry_count %0d, want %0d",
                                    out_word.entry_count, want.entry_count));
          if (out_word.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", out_word.status, want.status));
        end
        reports_seen++;
      end
      if (in_valid && in_ready) begin
        advance_queue_model(in_word, pred);
        expected_reports.push_back(pred);
        words_taken++;
      end
    end
  end

  // Long receive stall so the output register fills and the block stops taking words
  initial begin
    while (words_taken < HOLD_AT) @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    logic signed [DATA_W-1:0] fill_prio [11];
    int   bias;
    int   run_left;
    cmd_t c;

    // directed: remove on empty, extremes, ties at the head and in the middle
    fill_prio = '{-1, 1, 5, 5, 32'sh4000_0000, 32'shc000_0000, 3, 32'sh7fff_ffff,
                  32'sh8000_0001, 0, -4};
    feed_q.push_back(make_word(CMD_REMOVE, 32'sh1234_5678, 32'sh0));
    feed_q.push_back(make_word(CMD_INSERT, 32'sh7fff_ffff, 32'sh0));
    feed_q.push_back(make_word(CMD_INSERT, 32'sh8000_0000, 32'sh8000_0000));
    feed_q.push_back(make_word(CMD_INSERT, -32'sd1, 32'sh7fff_ffff));
    feed_q.push_back(make_word(CMD_INSERT, 32'sh5a5a_5a5a, 32'sh8000_0000));
    feed_q.push_back(make_word(CMD_INSERT, 32'sd1, 32'sh0));
    foreach (fill_prio[k])
      feed_q.push_back(make_word(CMD_INSERT, $urandom, fill_prio[k]));
    // queue now full: this one is dropped
    feed_q.push_back(make_word(CMD_INSERT, 32'sha5a5_a5a5, 32'sh8000_0000));
    feed_q.push_back(make_word(CMD_REMOVE, 32'sh0, 32'sh0));
    feed_q.push_back(make_word(CMD_REMOVE, -32'sd1, -32'sd1));
    feed_q.push_back(make_word(CMD_INSERT, 32'sh0, -32'sd1));
    feed_q.push_back(make_word(CMD_REMOVE, 32'sh0, 32'sh0));

    // random: runs biased to fill, drain or hover, so full and empty recur
    bias = 50;
    run_left = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0:       bias = 85;
          1:       bias = 15;
          default: bias = 50;
        endcase
      end
      run_left--;
      c = ($urandom_range(0, 99) < bias) ? CMD_INSERT : CMD_REMOVE;
      feed_q.push_back(make_word(c, $urandom, pick_priority()));
    end
    total_words = feed_q.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (words_taken < total_words) @(negedge clk);
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_reports.size() != 0)
      flag_mismatch($sformatf("%0d result words never arrived", expected_reports.size()));

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
